// File: sv/hpu_pkg.sv
// Shared types and constants for the horizontal predictor undo block.
`default_nettype none

package hpu_pkg;

    localparam int MAX_COMPONENTS = 4;
    localparam int COLUMN_BITS    = 16;
    localparam int RESULT_LIMIT   = 5;
    localparam int CIDX_W         = $clog2(MAX_COMPONENTS);
    localparam int RCNT_W         = $clog2(RESULT_LIMIT + 1);

    typedef enum logic [2:0] {
        REG_ROW_WIDTH  = 3'd0,
        REG_COMP_COUNT = 3'd1,
        REG_BITS_C0    = 3'd2,
        REG_BITS_C1    = 3'd3,
        REG_BITS_C2    = 3'd4,
        REG_BITS_C3    = 3'd5
    } cfg_reg_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_BIT,
        ST_DRAIN,
        ST_END,
        ST_ZERO,
        ST_SEND
    } state_t;

    typedef struct packed {
        logic accept;
        logic take_bit;
        logic drain;
        logic pad;
        logic trunc_start;
        logic zero;
        logic clear;
    } dp_cmd_t;

    typedef struct packed {
        logic sample_done;
        logic bit_last;
        logic bits_empty;
        logic pend_ge8;
        logic row_done;
        logic seg_end;
        logic trunc_needed;
        logic zeros_done;
    } dp_stat_t;

    typedef struct packed {
        logic clear;
        logic send;
        logic trunc_set;
    } ob_cmd_t;

endpackage

`default_nettype wire

// File: sv/hpu_dp.sv
// Datapath: config registers, bit gatherer, running sums and output bit packer.
`default_nettype none

module hpu_dp (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_we,
    input  logic [2:0]        cfg_index,
    input  logic [15:0]       cfg_data,
    input  logic [7:0]        in_byte,
    input  logic              in_seg_end,
    input  hpu_pkg::dp_cmd_t  cmd,
    output hpu_pkg::dp_stat_t stat,
    output logic              push_valid,
    output logic [7:0]        push_data
);
    import hpu_pkg::*;

    // configuration
    logic [COLUMN_BITS-1:0] row_width_reg;
    logic [2:0]             comp_count_reg;
    logic [5:0]             comp_bits_reg [4];

    // per-beat working state
    logic [7:0]  byte_reg;
    logic [3:0]  bits_left_reg;
    logic        seg_end_reg;
    logic        row_done_reg;
    logic [2:0]  zeros_reg;

    // stream state
    logic [31:0]            run_sum_reg [MAX_COMPONENTS];
    logic [31:0]            gather_reg;
    logic [5:0]             gcnt_reg;
    logic [CIDX_W-1:0]      comp_idx_reg;
    logic [COLUMN_BITS-1:0] col_reg;
    logic [39:0]            pend_reg;
    logic [5:0]             pcnt_reg;

    logic [2:0]             eff_comp;
    logic [CIDX_W-1:0]      comp_sel;
    logic [5:0]             wraw;
    logic [5:0]             width;
    logic [31:0]            gather_nx;
    logic [5:0]             gcnt_inc;
    logic                   sample_done;
    logic [31:0]            mask;
    logic [31:0]            sum;
    logic [2:0]             comp_nx;
    logic                   comp_wrap;
    logic [COLUMN_BITS-1:0] col_inc;
    logic [COLUMN_BITS-1:0] width_lim;
    logic                   row_end;
    logic [39:0]            pend_app;
    logic [5:0]             pcnt_dr;
    logic [7:0]             drain_byte;
    logic [39:0]            pend_dr;
    logic [7:0]             pad_byte;
    logic [6:0]             total_bits;
    logic [2:0]             zero_load;
    logic                   stream_clr;
    logic                   cfg_hit;

    always_comb begin
        if (comp_count_reg == 3'd0) begin
            eff_comp = 3'd1;
        end else if (comp_count_reg > 3'(MAX_COMPONENTS)) begin
            eff_comp = 3'(MAX_COMPONENTS);
        end else begin
            eff_comp = comp_count_reg;
        end
    end

    assign comp_sel = (3'(comp_idx_reg) >= eff_comp) ? '0 : comp_idx_reg;
    assign wraw     = comp_bits_reg[comp_sel];

    always_comb begin
        if (wraw == 6'd0) begin
            width = 6'd1;
        end else if (wraw > 6'd32) begin
            width = 6'd32;
        end else begin
            width = wraw;
        end
    end

    assign gather_nx   = {gather_reg[30:0], byte_reg[7]};
    assign gcnt_inc    = gcnt_reg + 6'd1;
    assign sample_done = (gcnt_inc >= width);
    assign mask        = 32'hFFFF_FFFF >> (6'd32 - width);
    assign sum         = (gather_nx + run_sum_reg[comp_sel]) & mask;
    assign comp_nx     = 3'(comp_sel) + 3'd1;
    assign comp_wrap   = (comp_nx >= eff_comp);
    assign col_inc     = col_reg + 1'b1;
    assign width_lim   = (row_width_reg == '0) ? COLUMN_BITS'(1) : row_width_reg;
    assign row_end     = sample_done && comp_wrap &&
                         ((col_inc == '0) || (col_inc >= width_lim));

    assign pend_app    = (pend_reg << width) | {8'd0, sum};
    assign pcnt_dr     = pcnt_reg - 6'd8;
    assign drain_byte  = 8'(pend_reg >> pcnt_dr);
    assign pend_dr     = pend_reg & ((40'd1 << pcnt_dr) - 40'd1);
    assign pad_byte    = pend_reg[7:0] << (4'd8 - pcnt_reg[3:0]);
    assign total_bits  = 7'(pcnt_reg) + 7'(gcnt_reg);
    assign zero_load   = 3'((total_bits + 7'd7) >> 3) - 3'(pcnt_reg != 6'd0);

    assign cfg_hit    = cfg_we && (cfg_index <= 3'(REG_BITS_C3));
    assign stream_clr = cmd.clear || cfg_hit;

    assign stat.sample_done  = sample_done;
    assign stat.bit_last     = (bits_left_reg == 4'd1);
    assign stat.bits_empty   = (bits_left_reg == 4'd0);
    assign stat.pend_ge8     = (pcnt_reg >= 6'd8);
    assign stat.row_done     = row_done_reg;
    assign stat.seg_end      = seg_end_reg;
    assign stat.trunc_needed = (col_reg != '0) || (comp_idx_reg != '0) || (gcnt_reg != 6'd0);
    assign stat.zeros_done   = (zeros_reg == 3'd0);

    assign push_valid = cmd.drain || cmd.zero ||
                        ((cmd.pad || cmd.trunc_start) && (pcnt_reg != 6'd0));
    assign push_data  = cmd.drain ? drain_byte :
                        (cmd.pad || cmd.trunc_start) ? pad_byte : 8'd0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_width_reg  <= COLUMN_BITS'(1);
            comp_count_reg <= 3'd1;
            for (int i = 0; i < 4; i++) begin
                comp_bits_reg[i] <= 6'd8;
            end
        end else if (cfg_we) begin
            case (cfg_reg_t'(cfg_index))
                REG_ROW_WIDTH:  row_width_reg    <= cfg_data[COLUMN_BITS-1:0];
                REG_COMP_COUNT: comp_count_reg   <= cfg_data[2:0];
                REG_BITS_C0:    comp_bits_reg[0] <= cfg_data[5:0];
                REG_BITS_C1:    comp_bits_reg[1] <= cfg_data[5:0];
                REG_BITS_C2:    comp_bits_reg[2] <= cfg_data[5:0];
                REG_BITS_C3:    comp_bits_reg[3] <= cfg_data[5:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            byte_reg      <= '0;
            bits_left_reg <= '0;
            seg_end_reg   <= 1'b0;
            row_done_reg  <= 1'b0;
            zeros_reg     <= '0;
        end else begin
            if (cmd.accept) begin
                byte_reg      <= in_byte;
                bits_left_reg <= 4'd8;
                seg_end_reg   <= in_seg_end;
                row_done_reg  <= 1'b0;
            end
            if (cmd.take_bit) begin
                byte_reg      <= {byte_reg[6:0], 1'b0};
                bits_left_reg <= bits_left_reg - 4'd1;
                if (row_end) begin
                    row_done_reg <= 1'b1;
                end
            end
            if (cmd.trunc_start) begin
                zeros_reg <= zero_load;
            end else if (cmd.zero) begin
                zeros_reg <= zeros_reg - 3'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || stream_clr) begin
            for (int i = 0; i < MAX_COMPONENTS; i++) begin
                run_sum_reg[i] <= '0;
            end
            gather_reg   <= '0;
            gcnt_reg     <= '0;
            comp_idx_reg <= '0;
            col_reg      <= '0;
            pend_reg     <= '0;
            pcnt_reg     <= '0;
        end else if (cmd.take_bit) begin
            if (!sample_done) begin
                gather_reg <= gather_nx;
                gcnt_reg   <= gcnt_inc;
            end else begin
                gather_reg <= '0;
                gcnt_reg   <= '0;
                pend_reg   <= pend_app;
                pcnt_reg   <= pcnt_reg + width;
                if (row_end) begin
                    // new row: sums restart from zero
                    for (int i = 0; i < MAX_COMPONENTS; i++) begin
                        run_sum_reg[i] <= '0;
                    end
                    comp_idx_reg <= '0;
                    col_reg      <= '0;
                end else begin
                    run_sum_reg[comp_sel] <= sum;
                    if (comp_wrap) begin
                        comp_idx_reg <= '0;
                        col_reg      <= col_inc;
                    end else begin
                        comp_idx_reg <= comp_nx[CIDX_W-1:0];
                    end
                end
            end
        end else if (cmd.drain) begin
            pend_reg <= pend_dr;
            pcnt_reg <= pcnt_dr;
        end else if (cmd.pad || cmd.trunc_start) begin
            pend_reg <= '0;
            pcnt_reg <= '0;
        end
    end

endmodule

`default_nettype wire

// File: sv/hpu_ctrl.sv
// Controller state machine sequencing bits, drains, padding and result send.
`default_nettype none

module hpu_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  hpu_pkg::dp_stat_t stat,
    input  logic              send_done,
    output hpu_pkg::dp_cmd_t  dp_cmd,
    output hpu_pkg::ob_cmd_t  ob_cmd
);
    import hpu_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) state_next = ST_BIT;
            end
            ST_BIT: begin
                if (stat.sample_done) begin
                    state_next = ST_DRAIN;
                end else if (stat.bit_last) begin
                    state_next = ST_END;
                end
            end
            ST_DRAIN: begin
                if (!stat.pend_ge8) begin
                    if (stat.row_done || stat.bits_empty) begin
                        state_next = ST_END;
                    end else begin
                        state_next = ST_BIT;
                    end
                end
            end
            ST_END: begin
                if (stat.seg_end && stat.trunc_needed) begin
                    state_next = ST_ZERO;
                end else begin
                    state_next = ST_SEND;
                end
            end
            ST_ZERO: begin
                if (stat.zeros_done) state_next = ST_SEND;
            end
            ST_SEND: begin
                if (send_done) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        dp_cmd   = '0;
        ob_cmd   = '0;
        s_tready = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_tready      = 1'b1;
                dp_cmd.accept = s_tvalid;
                ob_cmd.clear  = s_tvalid;
            end
            ST_BIT: begin
                dp_cmd.take_bit = 1'b1;
            end
            ST_DRAIN: begin
                if (stat.pend_ge8) begin
                    dp_cmd.drain = 1'b1;
                end else if (stat.row_done) begin
                    dp_cmd.pad = 1'b1;
                end
            end
            ST_END: begin
                if (stat.seg_end && stat.trunc_needed) begin
                    dp_cmd.trunc_start = 1'b1;
                    ob_cmd.trunc_set   = 1'b1;
                end else if (stat.seg_end) begin
                    dp_cmd.clear = 1'b1;
                end
            end
            ST_ZERO: begin
                if (!stat.zeros_done) begin
                    dp_cmd.zero = 1'b1;
                end else begin
                    dp_cmd.clear = 1'b1;
                end
            end
            ST_SEND: begin
                ob_cmd.send = 1'b1;
            end
            default: ;
        endcase
    end

endmodule

`default_nettype wire

// File: sv/hpu_obuf.sv
// Result buffer: collects one beat's output bytes and plays them out.
`default_nettype none

module hpu_obuf (
    input  logic             aclk,
    input  logic             aresetn,
    input  hpu_pkg::ob_cmd_t cmd,
    input  logic             push_valid,
    input  logic [7:0]       push_data,
    output logic             send_done,
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [7:0]       m_tdata,
    output logic             m_tlast,
    output logic             m_tuser
);
    import hpu_pkg::*;

    logic [7:0]        res_reg [RESULT_LIMIT];
    logic [RCNT_W-1:0] count_reg;
    logic [RCNT_W-1:0] rd_reg;
    logic              trunc_reg;

    assign send_done = (rd_reg == count_reg);
    assign m_tvalid  = cmd.send && !send_done;
    assign m_tdata   = (rd_reg < RCNT_W'(RESULT_LIMIT)) ? res_reg[rd_reg] : 8'd0;
    assign m_tlast   = (rd_reg == count_reg - 1'b1);
    assign m_tuser   = trunc_reg;

    always_ff @(posedge aclk) begin
        if (push_valid && (count_reg < RCNT_W'(RESULT_LIMIT))) begin
            res_reg[count_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || cmd.clear) begin
            count_reg <= '0;
            rd_reg    <= '0;
            trunc_reg <= 1'b0;
        end else begin
            if (push_valid && (count_reg < RCNT_W'(RESULT_LIMIT))) begin
                count_reg <= count_reg + 1'b1;
            end
            if (cmd.trunc_set) begin
                trunc_reg <= 1'b1;
            end
            if (m_tvalid && m_tready) begin
                rd_reg <= rd_reg + 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

// File: sv/horizontal_predictor_undo_top.sv
// Sequence: a beat's eight bits (fewer when a row ends inside it) are gathered one bit per cycle,
// pausing after each completed sample while whole output bytes drain and a row end is padded;
// then an end check, a zero fill on a truncated segment end, and the play-out of the results.
// One beat is worked on at a time: no new beat is taken until all its results have been taken.
// The bit-serial gatherer and the single running-sum adder set the pace.
// Reset (aresetn low, synchronous) clears all stream state and loads default config.
`default_nettype none

module horizontal_predictor_undo_top (
    input  logic        aclk,
    input  logic        aresetn,
    // configuration write port
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // [7:0] data_byte
    input  logic        s_tlast,    // segment_end
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,    // [7:0] out_byte
    output logic        m_tlast,    // last_of_run
    output logic        m_tuser     // [0] truncated_row
);
    import hpu_pkg::*;

    dp_cmd_t    dp_cmd;
    dp_stat_t   dp_stat;
    ob_cmd_t    ob_cmd;
    logic       send_done;
    logic       push_valid;
    logic [7:0] push_data;

    // sequencer: one bit per cycle, paused for drains and padding, then play out results
    hpu_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .stat      (dp_stat),
        .send_done (send_done),
        .dp_cmd    (dp_cmd),
        .ob_cmd    (ob_cmd)
    );

    // sample gather, modulo add against running sum, output bit packing
    hpu_dp u_dp (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_byte    (s_tdata),
        .in_seg_end (s_tlast),
        .cmd        (dp_cmd),
        .stat       (dp_stat),
        .push_valid (push_valid),
        .push_data  (push_data)
    );

    // holds up to five bytes per input beat; extra bytes of a beat are dropped
    hpu_obuf u_obuf (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (ob_cmd),
        .push_valid (push_valid),
        .push_data  (push_data),
        .send_done  (send_done),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast),
        .m_tuser    (m_tuser)
    );

endmodule

`default_nettype wire

// File: sv/hpu_checker.sv
// Port-level checker for the horizontal predictor undo block, with its bind.
`default_nettype none

module hpu_checker (
    input logic aclk,
    input logic aresetn,
    input logic s_tvalid,
    input logic s_tready,
    input logic m_tvalid,
    input logic m_tready,
    input logic m_tlast
);

    // stalled result beat stays offered
    a_m_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result beat withdrawn while stalled");

    // input side closed while results are being played out
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_tready && m_tvalid))
        else $error("input ready while results pending");

    // one beat worked on at a time
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input ready right after accept");

    // results of one beat leave back to back until the last
    a_run_continues: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready && !m_tlast |=> m_tvalid)
        else $error("result run broken before last");

    // after reset: idle and ready
    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> s_tready && !m_tvalid)
        else $error("not idle after reset");

endmodule

bind horizontal_predictor_undo_top hpu_checker u_hpu_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tlast  (m_tlast)
);

`default_nettype wire

// File: tb/sv/testbench.sv
// Self-checking testbench for the horizontal predictor undo block.
`timescale 1ns / 100ps

import hpu_pkg::*;

typedef struct {
    logic [7:0] out_byte;
    logic       last_of_run;
    logic       truncated_row;
} restored_byte_t;

// Restores each accepted beat itself and holds the bytes it owes the block.
class row_restore_sb;
    logic [15:0]    row_width;
    logic [2:0]     comp_count;
    logic [5:0]     comp_bits [4];
    logic [31:0]    run_sum [MAX_COMPONENTS];
    logic [31:0]    gather;
    int             gathered;
    int             comp_idx;
    logic [15:0]    column;
    logic [63:0]    pend;
    int             pend_bits;
    logic [7:0]     step_q [$];
    restored_byte_t restored_q [$];
    int             errors;

    function new();
        row_width  = 16'd1;
        comp_count = 3'd1;
        foreach (comp_bits[c]) comp_bits[c] = 6'd8;
        errors = 0;
        clear_stream();
    endfunction

    function void clear_stream();
        foreach (run_sum[c]) run_sum[c] = '0;
        gather    = '0;
        gathered  = 0;
        comp_idx  = 0;
        column    = '0;
        pend      = '0;
        pend_bits = 0;
    endfunction

    function int eff_comps();
        int lim;
        int n;
        lim = (MAX_COMPONENTS < 4) ? MAX_COMPONENTS : 4;
        n   = (comp_count == 0) ? 1 : int'(comp_count);
        return (n > lim) ? lim : n;
    endfunction

    function int eff_width(int c);
        int w;
        w = comp_bits[c & 3];
        if (w == 0) w = 1;
        if (w > 32) w = 32;
        return w;
    endfunction

    function int eff_row();
        return (row_width == 0) ? 1 : int'(row_width);
    endfunction

    function void write_reg(logic [2:0] idx, logic [15:0] val);
        case (idx)
            REG_ROW_WIDTH:  row_width    = val;
            REG_COMP_COUNT: comp_count   = val[2:0];
            REG_BITS_C0:    comp_bits[0] = val[5:0];
            REG_BITS_C1:    comp_bits[1] = val[5:0];
            REG_BITS_C2:    comp_bits[2] = val[5:0];
            REG_BITS_C3:    comp_bits[3] = val[5:0];
            default:        return;
        endcase
        // any valid write restarts the segment
        clear_stream();
    endfunction

    function void emit(logic [63:0] v);
        if (step_q.size() < RESULT_LIMIT) step_q.push_back(v[7:0]);
    endfunction

    function void drain();
        while (pend_bits >= 8) begin
            pend_bits -= 8;
            emit(pend >> pend_bits);
            pend &= (64'd1 << pend_bits) - 64'd1;
        end
    endfunction

    function void pad();
        if (pend_bits > 0 && pend_bits < 8) emit(pend << (8 - pend_bits));
        pend      = '0;
        pend_bits = 0;
    endfunction

    function void note_beat(logic [7:0] data, logic seg_end);
        logic        trunc;
        logic [63:0] mask;
        logic [63:0] sum;
        int          c;
        int          w;
        int          nbytes;
        trunc = 1'b0;
        step_q.delete();
        for (int i = 7; i >= 0; i--) begin
            c = comp_idx;
            if (c >= eff_comps()) c = 0;
            w = eff_width(c);
            gather = {gather[30:0], data[i]};
            gathered++;
            if (gathered >= w) begin
                mask = (64'd1 << w) - 64'd1;
                sum  = ({32'd0, gather} + {32'd0, run_sum[c % MAX_COMPONENTS]}) & mask;
                run_sum[c % MAX_COMPONENTS] = sum[31:0];
                gather    = '0;
                gathered  = 0;
                pend      = (pend << w) | sum;
                pend_bits += w;
                drain();
                c++;
                if (c < eff_comps()) begin
                    comp_idx = c;
                end else begin
                    comp_idx = 0;
                    column   = column + 16'd1;
                    if (column == 0 || column >= eff_row()) begin
                        // row done: sums clear, rest of byte skipped, output padded
                        column = '0;
                        foreach (run_sum[k]) run_sum[k] = '0;
                        pad();
                        break;
                    end
                end
            end
        end
        if (seg_end) begin
            if (column != 0 || comp_idx != 0 || gathered != 0) begin
                // segment cut inside a row: flush, then zero-fill
                trunc  = 1'b1;
                nbytes = (pend_bits + gathered + 7) / 8;
                if (pend_bits > 0) begin
                    pad();
                    nbytes--;
                end
                repeat (nbytes) emit('0);
            end
            clear_stream();
        end
        foreach (step_q[k])
            restored_q.push_back('{step_q[k], (k == step_q.size() - 1), trunc});
    endfunction

    function void check_byte(logic [7:0] b, logic last, logic trunc);
        restored_byte_t want;
        if (restored_q.size() == 0) begin
            errors++;
            if (errors <= 10)
                $display("mismatch: unexpected byte %02h last %0b trunc %0b", b, last, trunc);
            return;
        end
        want = restored_q.pop_front();
        if (want.out_byte !== b || want.last_of_run !== last || want.truncated_row !== trunc) begin
            errors++;
            if (errors <= 10)
                $display("mismatch: byte exp %02h got %02h, last exp %0b got %0b, trunc exp %0b got %0b",
                         want.out_byte, b, want.last_of_run, last, want.truncated_row, trunc);
        end
    endfunction
endclass

module testbench;

    localparam int CLK_HALF       = 4;
    localparam int RESET_CYCLES   = 7;
    localparam int RANDOM_ITEMS   = 394;   // plus the directed beats, about 410 in all
    localparam int PHASE_ITEMS    = 34;
    localparam int SETTLE_CYCLES  = 40;    // worst beat latency with margin
    localparam int HOLD_CYCLES    = 400;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int MAX_ROW_BITS   = 160;   // keeps random rows short

    // segment shapes for the random part
    localparam int SEG_WHOLE = 0;
    localparam int SEG_CUT   = 1;
    localparam int SEG_NOISE = 2;

    // indexes outside the register map, to be ignored by the block
    localparam logic [2:0] REG_SPARE_6 = 3'd6;
    localparam logic [2:0] REG_SPARE_7 = 3'd7;

    logic        aclk;
    logic        aresetn;
    logic        cfg_we;
    logic [2:0]  cfg_index;
    logic [15:0] cfg_data;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready;
    logic [7:0]  m_tdata;
    logic        m_tlast;
    logic        m_tuser;

    row_restore_sb sb;
    int            send_idle_pct;
    int            recv_idle_pct;
    bit            hold_req;
    int            random_sent;
    int            stuck_cycles = 0;

    horizontal_predictor_undo_top dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser)
    );

    always begin
        aclk = 1'b0;
        #CLK_HALF;
        aclk = 1'b1;
        #CLK_HALF;
    end

    // Offer one beat from a falling edge, with random idle cycles in front;
    // returns at the falling edge after acceptance with tvalid still high.
    task automatic send_beat(input logic [7:0] data, input logic seg_end);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= data;
        s_tlast  <= seg_end;
        do @(posedge aclk); while (!s_tready);
        sb.note_beat(data, seg_end);
        @(negedge aclk);
    endtask

    // Each write ends with cfg_we low again, so that back-to-back writes never collide on cfg_we.
    task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        sb.write_reg(idx, val);
        @(negedge aclk);
        cfg_we <= 1'b0;
        @(negedge aclk);
    endtask

    // Stop offering, let every owed byte arrive, then allow for a beat that
    // is still being worked on but owes nothing.
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (sb.restored_q.size() != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    function automatic int pixel_bits();
        int total;
        total = 0;
        for (int c = 0; c < sb.eff_comps(); c++) total += sb.eff_width(c);
        return total;
    endfunction

    // New random setting; junk in the unused upper bits of cfg_data.
    // Row width is written last so that the row length stays bounded.
    task automatic random_config();
        logic [15:0] v;
        int          rw;
        int          max_rw;
        v      = 16'($urandom);
        v[2:0] = 3'($urandom_range(0, 7));
        write_reg(REG_COMP_COUNT, v);
        for (int c = 0; c < 4; c++) begin
            v      = 16'($urandom);
            v[5:0] = ($urandom_range(0, 7) == 0) ? 6'($urandom_range(0, 63))
                                                 : 6'($urandom_range(1, 12));
            write_reg(3'(REG_BITS_C0 + c), v);
        end
        rw     = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 1) : $urandom_range(1, 6);
        max_rw = MAX_ROW_BITS / pixel_bits();
        if (max_rw < 1) max_rw = 1;
        if (rw > max_rw) rw = max_rw;
        write_reg(REG_ROW_WIDTH, 16'(rw));
    endtask

    task automatic send_segment(input int shape);
        int row_bytes;
        int n;
        row_bytes = (sb.eff_row() * pixel_bits() + 7) / 8;
        case (shape)
            SEG_WHOLE: begin
                // whole rows, ending cleanly on a row boundary
                n = $urandom_range(1, 3) * row_bytes;
                for (int i = 0; i < n; i++) send_beat(8'($urandom_range(0, 255)), i == n - 1);
            end
            SEG_CUT: begin
                // segment end usually lands inside a row
                n = $urandom_range(1, 2 * row_bytes);
                for (int i = 0; i < n; i++) send_beat(8'($urandom_range(0, 255)), i == n - 1);
            end
            default: begin
                n = $urandom_range(1, 6);
                for (int i = 0; i < n; i++)
                    send_beat(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
            end
        endcase
        random_sent += n;
    endtask

    // Receiver: random tready, or one long hold-off when asked, so the block
    // fills up and has to stall its input.
    initial begin
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_req) begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
                hold_req = 1'b0;
            end else begin
                m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
            end
        end
    end

    // Every accepted result beat is checked against the oldest owed byte.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) sb.check_byte(m_tdata, m_tlast, m_tuser);
    end

    // Watchdog: too long without any beat or register write means a hang.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we) begin
            stuck_cycles <= 0;
        end else if (stuck_cycles >= WATCHDOG_LIMIT) begin
            $display("tb: failure");
            $finish;
        end else begin
            stuck_cycles <= stuck_cycles + 1;
        end
    end

    initial begin
        int pick;
        int next_phase_at;
        int phase;
        aresetn       = 1'b0;
        cfg_we        = 1'b0;
        cfg_index     = REG_ROW_WIDTH;
        cfg_data      = '0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        s_tlast       = 1'b0;
        send_idle_pct = 31;
        recv_idle_pct = 47;
        hold_req      = 1'b0;
        random_sent   = 0;
        next_phase_at = 0;
        phase         = 0;
        sb            = new();
        repeat (RESET_CYCLES) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Reset setting: one 8-bit sample per row, segment end on a boundary.
        send_beat(8'h00, 1'b0);
        send_beat(8'hFF, 1'b0);
        send_beat(8'hA5, 1'b1);

        // Zero row width, zero count and zero width all act as one:
        // one bit per row, the rest of each byte skipped.
        wait_idle();
        write_reg(REG_ROW_WIDTH, 16'h0000);
        write_reg(REG_COMP_COUNT, 16'h0000);
        write_reg(REG_BITS_C0, 16'h0000);
        send_beat(8'hFF, 1'b0);
        send_beat(8'h80, 1'b0);
        send_beat(8'h7F, 1'b1);

        // Count above four saturates, widths above 32 saturate, and the
        // segment ends inside a row.
        wait_idle();
        write_reg(REG_ROW_WIDTH, 16'd3);
        write_reg(REG_COMP_COUNT, 16'd7);
        write_reg(REG_BITS_C0, 16'd63);
        write_reg(REG_BITS_C1, 16'd33);
        write_reg(REG_BITS_C2, 16'd1);
        write_reg(REG_BITS_C3, 16'd5);
        send_beat(8'hFF, 1'b0);
        send_beat(8'h00, 1'b0);
        send_beat(8'h5A, 1'b0);
        send_beat(8'hC3, 1'b1);

        // Widest row and widest samples; left mid-row so that the next
        // write has to drop the pending bits.
        wait_idle();
        write_reg(REG_ROW_WIDTH, 16'hFFFF);
        write_reg(REG_COMP_COUNT, 16'd5);
        write_reg(REG_BITS_C0, 16'd32);
        write_reg(REG_BITS_C1, 16'd32);
        write_reg(REG_BITS_C2, 16'd32);
        write_reg(REG_BITS_C3, 16'd32);
        send_beat(8'hFF, 1'b0);
        send_beat(8'hFF, 1'b0);
        send_beat(8'h01, 1'b0);

        // Rows straddling bytes; writes to unmapped indexes must leave the
        // segment running.
        wait_idle();
        write_reg(REG_ROW_WIDTH, 16'd2);
        write_reg(REG_COMP_COUNT, 16'd2);
        write_reg(REG_BITS_C0, 16'd3);
        write_reg(REG_BITS_C1, 16'd2);
        send_beat(8'hB6, 1'b0);
        wait_idle();
        write_reg(REG_SPARE_6, 16'hFFFF);
        write_reg(REG_SPARE_7, 16'h0000);
        send_beat(8'h4D, 1'b0);
        send_beat(8'hE1, 1'b1);

        // Random part: mostly whole-row segments, some cut short, some noise.
        // Idling goes sender-light, then receiver-light, then none at all.
        while (random_sent < RANDOM_ITEMS) begin
            if (random_sent >= next_phase_at) begin
                wait_idle();
                random_config();
                next_phase_at += PHASE_ITEMS;
                phase++;
                if (phase == 3) hold_req = 1'b1;
            end
            if (random_sent < RANDOM_ITEMS / 3) begin
                send_idle_pct = 31;
                recv_idle_pct = 47;
            end else if (random_sent < 2 * RANDOM_ITEMS / 3) begin
                send_idle_pct = 47;
                recv_idle_pct = 31;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            pick = $urandom_range(0, 99);
            send_segment((pick < 70) ? SEG_WHOLE : (pick < 85) ? SEG_CUT : SEG_NOISE);
        end

        wait_idle();
        if (sb.errors == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
